[hdl/swlt_pkg.sv]
// ----------------------------------------------------------------------------
// swlt_pkg
// Shared widths, register indexes, reset values and helpers for the sliding
// window lane tracker.
// ----------------------------------------------------------------------------
package swlt_pkg;

  // Field and state widths
  localparam int XW      = 10;  // pixel column
  localparam int CW      = 11;  // lane center, 0 .. image width
  localparam int CNTW    = 18;  // set pixel count per side
  localparam int SUMW    = 28;  // column sum per side
  localparam int WINW    = 6;   // window number
  localparam int ROWW    = 8;   // row within a window
  localparam int SW      = 13;  // signed range arithmetic
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 10;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_WINDOW_HEIGHT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MIN_PIXELS    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MARGIN        = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DRIFT         = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SPLIT_COLUMN  = 3'd4;

  // Configuration reset values
  localparam logic [7:0] WINDOW_HEIGHT_RST = 8'd26;
  localparam logic [7:0] MIN_PIXELS_RST    = 8'd3;
  localparam logic [8:0] MARGIN_RST        = 9'd50;
  localparam logic [5:0] DRIFT_RST         = 6'd12;
  localparam logic [9:0] SPLIT_COLUMN_RST  = 10'd384;

  // Search range of one side, half open [lo, hi)
  typedef struct packed {
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
  } range_t;

  // Clamp a signed value to [0, w]
  function automatic logic [CW-1:0] clamp_w(input logic signed [SW-1:0] v,
                                            input logic [CW-1:0] w);
    logic [CW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({2'b00, w})) begin
      r = w;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

[hdl/sliding_window_lane_tracker_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_lane_tracker_core
// Streams a binary image, bottom row first, and reports one left and right
// lane point per stacked search window.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry one pixel each: its value and column in tdata,
//   the row end mark in tlast and the frame start mark in tuser. One output
//   beat on m_* is produced at the end of each search window; tlast marks the
//   final window of the frame. Registers are written through cfg_we, cfg_addr
//   and cfg_data while the block is idle.
//   Timing: a pixel is taken in the idle state and worked in the next cycle,
//   in the pixel state, so the next pixel is taken only once it is worked.
//   A pixel that closes a window passes through the pixel step, then runs
//   the shared restoring divider for the left and then the right side, 28
//   steps plus a finishing step each, and a last step builds the result once
//   the output register is free. s_tready is low meanwhile.
//   The result sits in an output register, so new pixels are taken while it
//   waits; only the next window close waits for the receiver to drain it.
//   Reset clears all counters, tracking, centers and the output valid, and
//   loads the register defaults. Frame start clears tracking and counters;
//   after the last window, pixels are dropped until the next frame start.
// ----------------------------------------------------------------------------
module sliding_window_lane_tracker_core
  import swlt_pkg::*;
#(
  parameter int NUM_WINDOWS = 18,
  parameter int IMG_WIDTH   = 768,
  parameter int IMG_HEIGHT  = 480
) (
  input  logic              clk,
  input  logic              rst,
  // Pixel stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [0] pixel_on, [10:1] x_pos, zero pad
  input  logic              s_tlast,   // row_end
  input  logic              s_tuser,   // frame_start
  // Window results
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // [5:0] window_index, [15:6] center_row,
                                       // [16] left_found, [26:17] left_x,
                                       // [27] right_found, [37:28] right_x, pad
  output logic              m_tlast,   // last_window
  // Configuration writes
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PIX  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SIDE = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [CW-1:0]        ImgW     = CW'(IMG_WIDTH);
  localparam logic [WINW:0]        NumWin   = (WINW+1)'(NUM_WINDOWS);
  localparam logic signed [17:0]   TwoH     = 18'(2 * IMG_HEIGHT);
  localparam logic [4:0]           DivLast  = 5'(SUMW - 1);

  // Configuration registers
  logic [7:0] window_height;
  logic [7:0] min_pixels;
  logic [8:0] margin;
  logic [5:0] drift;
  logic [9:0] split_column;

  // Tracking state
  logic [2:0]      state;
  logic [ROWW-1:0] row_in_window;
  logic [WINW-1:0] window_count;
  logic [CW-1:0]   left_center;
  logic [CW-1:0]   right_center;
  logic            left_tracking;
  logic            right_tracking;
  logic [CNTW-1:0] left_count;
  logic [SUMW-1:0] left_sum;
  logic [CNTW-1:0] right_count;
  logic [SUMW-1:0] right_sum;
  logic            frame_done;

  // Captured pixel
  logic            in_pix;
  logic [XW-1:0]   in_x;
  logic            in_row_end;

  // Ranges held for the window close
  range_t          left_rng;
  range_t          right_rng;

  // Shared divider
  logic [SUMW-1:0] div_quo;
  logic [CNTW:0]   div_rem;
  logic [4:0]      div_cnt;
  logic            div_side;

  // Per-side results of the current window
  logic            res_lf;
  logic [XW-1:0]   res_lx;
  logic            res_rf;
  logic [XW-1:0]   res_rx;

  // Output register
  logic            out_valid;
  logic [39:0]     out_data;
  logic            out_last;

  logic            s_fire;
  assign s_fire   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);

  // Current search ranges of both sides
  logic            lt_en;
  logic            rt_en;
  range_t          l_rng_c;
  range_t          r_rng_c;
  logic signed [SW-1:0] split_s;

  always_comb begin
    lt_en   = (window_count != '0) && left_tracking;
    rt_en   = (window_count != '0) && right_tracking;
    split_s = $signed({3'b000, split_column});
    if (lt_en) begin
      l_rng_c.lo = clamp_w($signed({2'b00, left_center}) - $signed({4'b0000, margin}), ImgW);
      l_rng_c.hi = clamp_w($signed({2'b00, left_center}) + $signed({4'b0000, margin}), ImgW);
    end else begin
      l_rng_c.lo = '0;
      l_rng_c.hi = clamp_w(split_s - 13'sd1, ImgW);
    end
    if (rt_en) begin
      r_rng_c.lo = clamp_w($signed({2'b00, right_center}) - $signed({4'b0000, margin}), ImgW);
      r_rng_c.hi = clamp_w($signed({2'b00, right_center}) + $signed({4'b0000, margin}), ImgW);
    end else begin
      r_rng_c.lo = clamp_w(split_s, ImgW);
      r_rng_c.hi = ImgW;
    end
  end

  // Pixel hits and row bookkeeping
  logic            l_hit;
  logic            r_hit;
  logic [ROWW-1:0] row_inc;
  logic [7:0]      h_eff;

  always_comb begin
    l_hit   = in_pix && ({1'b0, in_x} >= l_rng_c.lo) && ({1'b0, in_x} < l_rng_c.hi);
    r_hit   = in_pix && ({1'b0, in_x} >= r_rng_c.lo) && ({1'b0, in_x} < r_rng_c.hi);
    row_inc = row_in_window + 1'b1;
    h_eff   = (window_height == '0) ? 8'd1 : window_height;
  end

  // Divider step: shift in the next dividend bit, subtract when it fits
  logic [CNTW-1:0] div_den;
  logic [CNTW:0]   rem_sh;
  logic            rem_ge;

  always_comb begin
    div_den = div_side ? right_count : left_count;
    rem_sh  = {div_rem[CNTW-1:0], div_quo[SUMW-1]};
    rem_ge  = rem_sh >= {1'b0, div_den};
  end

  // Finish one side: mean or range middle if found, else the old center; drift
  range_t          s_rng;
  logic            s_found;
  logic            s_inside;
  logic [CW:0]     s_mid;
  logic [CW-1:0]   s_mean;
  logic [CW-1:0]   s_base;
  logic [CW:0]     l_add;
  logic [CW-1:0]   l_new;
  logic [CW-1:0]   r_new;

  always_comb begin
    s_rng    = div_side ? right_rng : left_rng;
    s_found  = div_den > {10'b0, min_pixels};
    s_inside = ({17'b0, s_rng.lo} < div_quo) && (div_quo < {17'b0, s_rng.hi});
    s_mid    = ({1'b0, s_rng.lo} + {1'b0, s_rng.hi}) >> 1;
    s_mean   = s_inside ? div_quo[CW-1:0] : s_mid[CW-1:0];
    s_base   = s_found ? s_mean : (div_side ? right_center : left_center);
    l_add    = {1'b0, s_base} + {6'b0, drift};
    l_new    = (l_add > {1'b0, ImgW}) ? ImgW : l_add[CW-1:0];
    r_new    = (s_base < {5'b0, drift}) ? '0 : (s_base - {5'b0, drift});
  end

  // Center row of the window: 2H - (2i+1)h, halved, zero when negative
  logic [14:0]        row_prod;
  logic signed [17:0] row_sum;
  logic [XW-1:0]      center_row;
  logic               last_win;

  always_comb begin
    row_prod   = {8'b0, window_count, 1'b1} * {7'b0, h_eff};
    row_sum    = TwoH - $signed({3'b000, row_prod});
    center_row = (row_sum < 0) ? '0 : row_sum[XW:1];
    last_win   = ({1'b0, window_count} + 1'b1) >= NumWin;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_height <= WINDOW_HEIGHT_RST;
      min_pixels    <= MIN_PIXELS_RST;
      margin        <= MARGIN_RST;
      drift         <= DRIFT_RST;
      split_column  <= SPLIT_COLUMN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WINDOW_HEIGHT: window_height <= cfg_data[7:0];
        REG_MIN_PIXELS:    min_pixels    <= cfg_data[7:0];
        REG_MARGIN:        margin        <= cfg_data[8:0];
        REG_DRIFT:         drift         <= cfg_data[5:0];
        REG_SPLIT_COLUMN:  split_column  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Captured pixel payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_pix     <= s_tdata[0];
      in_x       <= s_tdata[XW:1];
      in_row_end <= s_tlast;
    end
  end

  // Sequencer, accumulators and shared divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      row_in_window  <= '0;
      window_count   <= '0;
      left_center    <= '0;
      right_center   <= '0;
      left_tracking  <= 1'b0;
      right_tracking <= 1'b0;
      left_count     <= '0;
      left_sum       <= '0;
      right_count    <= '0;
      right_sum      <= '0;
      frame_done     <= 1'b0;
      div_cnt        <= '0;
      div_side       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && m_tready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state <= ST_PIX;
            if (s_tuser) begin
              left_tracking  <= 1'b0;
              right_tracking <= 1'b0;
              row_in_window  <= '0;
              window_count   <= '0;
              left_count     <= '0;
              left_sum       <= '0;
              right_count    <= '0;
              right_sum      <= '0;
              frame_done     <= 1'b0;
            end
          end
        end
        ST_PIX: begin
          left_rng  <= l_rng_c;
          right_rng <= r_rng_c;
          state     <= ST_IDLE;
          if (!frame_done) begin
            if (l_hit) begin
              left_count <= left_count + 1'b1;
              left_sum   <= left_sum + SUMW'(in_x);
            end
            if (r_hit) begin
              right_count <= right_count + 1'b1;
              right_sum   <= right_sum + SUMW'(in_x);
            end
            if (in_row_end) begin
              row_in_window <= row_inc;
              if (row_inc >= h_eff) begin
                // Window closes: divide the left side first
                div_quo  <= l_hit ? (left_sum + SUMW'(in_x)) : left_sum;
                div_rem  <= '0;
                div_cnt  <= '0;
                div_side <= 1'b0;
                state    <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          div_rem <= rem_ge ? (rem_sh - {1'b0, div_den}) : rem_sh;
          div_quo <= {div_quo[SUMW-2:0], rem_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DivLast) begin
            state <= ST_SIDE;
          end
        end
        ST_SIDE: begin
          if (!div_side) begin
            res_lf      <= s_found;
            res_lx      <= s_found ? s_mean[XW-1:0] : '0;
            left_center <= l_new;
            if (s_found) begin
              left_tracking <= 1'b1;
            end
            // Then the right side
            div_quo  <= right_sum;
            div_rem  <= '0;
            div_cnt  <= '0;
            div_side <= 1'b1;
            state    <= ST_DIV;
          end else begin
            res_rf       <= s_found;
            res_rx       <= s_found ? s_mean[XW-1:0] : '0;
            right_center <= r_new;
            if (s_found) begin
              right_tracking <= 1'b1;
            end
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // Wait until the output register is free
          if (!out_valid || m_tready) begin
            out_valid     <= 1'b1;
            out_data      <= {2'b00, res_rx, res_rf, res_lx, res_lf, center_row,
                              window_count};
            out_last      <= last_win;
            left_count    <= '0;
            left_sum      <= '0;
            right_count   <= '0;
            right_sum     <= '0;
            row_in_window <= '0;
            window_count  <= window_count + 1'b1;
            if (last_win) begin
              frame_done <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  // Checks
  a_one_pixel_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("pixel accepted while the previous one is still being worked");

  a_centers_in_image: assert property (@(posedge clk) disable iff (rst)
    (left_center <= ImgW) && (right_center <= ImgW))
    else $error("lane center outside the image");

  a_fin_waits_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && out_valid && !m_tready |=> (state == ST_FIN) && out_valid)
    else $error("pending result overwritten while the receiver stalls");

  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIDE) |-> (div_cnt == 5'(SUMW)))
    else $error("side finished without a full division");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window lane tracker. A short table of
// hand-picked pixels opens the run, then several register settings each get a
// stream of random frames built around two lanes. Every accepted pixel goes
// through a local copy of the tracker, and each output beat is compared field
// by field with the oldest pending window point.
// ----------------------------------------------------------------------------
module tb;
  import swlt_pkg::*;

  localparam int NUM_WIN       = 18;
  localparam int IMG_W         = 768;
  localparam int IMG_H         = 480;
  localparam int LEFT          = 0;
  localparam int RIGHT         = 1;
  localparam int IDLE_PCT      = 35;
  localparam int SETTLE_CYCLES = 80;

  // One window point as it leaves the block: tlast on top of tdata[37:0].
  typedef struct packed {
    logic       last;
    logic [9:0] right_x;
    logic       right_found;
    logic [9:0] left_x;
    logic       left_found;
    logic [9:0] center_row;
    logic [5:0] window_index;
  } win_point_t;

  // One row of the hand-written pixel table.
  typedef struct {
    bit         fs;
    bit         pix;
    int         x;
    bit         re;
    bit         typed;
    win_point_t pt;
  } probe_t;

  // Register setting and stream shape of one random stretch.
  typedef struct {
    int height;
    int minpix;
    int margin;
    int drift;
    int split;
    int items;
    int max_row;
    int restart_pct;
    bit calm;
    bit hold;
  } phase_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata  = '0;   // [0] pixel_on, [10:1] x_pos, zero pad
  logic              s_tlast  = 1'b0; // row_end
  logic              s_tuser  = 1'b0; // frame_start
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [39:0]       m_tdata;         // [5:0] window_index, [15:6] center_row,
                                      // [16] left_found, [26:17] left_x,
                                      // [27] right_found, [37:28] right_x, pad
  logic              m_tlast;         // last_window
  logic              cfg_we   = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  sliding_window_lane_tracker_core #(
    .NUM_WINDOWS(NUM_WIN),
    .IMG_WIDTH  (IMG_W),
    .IMG_HEIGHT (IMG_H)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .cfg_we  (cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // Clock with a 10 ns period.
  initial begin
    forever #5 clk = ~clk;
  end

  // Tracker copy: registers, window progress and per-side lane state.
  logic [7:0]  cfg_height;
  logic [7:0]  cfg_minpix;
  logic [8:0]  cfg_margin;
  logic [5:0]  cfg_drift;
  logic [9:0]  cfg_split;
  logic [7:0]  win_row;
  logic [5:0]  win_num;
  int          lane_c[2];
  bit          lane_trk[2];
  logic [17:0] hits[2];
  logic [27:0] colsum[2];
  bit          frame_over;

  win_point_t  expected_points[$];
  int          mismatches = 0;
  bit          calm = 1'b0;

  function automatic int clamp_col(input int v);
    if (v < 0) return 0;
    if (v > IMG_W) return IMG_W;
    return v;
  endfunction

  function automatic void reset_tracker();
    cfg_height = WINDOW_HEIGHT_RST;
    cfg_minpix = MIN_PIXELS_RST;
    cfg_margin = MARGIN_RST;
    cfg_drift  = DRIFT_RST;
    cfg_split  = SPLIT_COLUMN_RST;
    win_row    = '0;
    win_num    = '0;
    frame_over = 1'b0;
    for (int sd = 0; sd < 2; sd++) begin
      lane_c[sd]   = 0;
      lane_trk[sd] = 1'b0;
      hits[sd]     = '0;
      colsum[sd]   = '0;
    end
  endfunction

  // Half-open search range of one side for the current window.
  function automatic void side_bounds(input int sd, output int lo, output int hi);
    if (win_num != 0 && lane_trk[sd]) begin
      lo = clamp_col(lane_c[sd] - int'(cfg_margin));
      hi = clamp_col(lane_c[sd] + int'(cfg_margin));
    end else if (sd == RIGHT) begin
      lo = clamp_col(int'(cfg_split));
      hi = IMG_W;
    end else begin
      lo = 0;
      hi = clamp_col(int'(cfg_split) - 1);
    end
  endfunction

  // Closes one side of a window and moves its center inward.
  function automatic void close_side(input int sd, output bit found,
                                     output logic [9:0] col);
    int lo;
    int hi;
    int mean;
    side_bounds(sd, lo, hi);
    found = 1'b0;
    col   = '0;
    if (hits[sd] > 18'(cfg_minpix) && hits[sd] != 0) begin
      mean = int'(colsum[sd] / 28'(hits[sd]));
      // A mean on or outside the range edge falls back to the range middle.
      if (!(lo < mean && mean < hi)) mean = (lo + hi) / 2;
      lane_c[sd]   = mean;
      lane_trk[sd] = 1'b1;
      found        = 1'b1;
      col          = mean[9:0];
    end
    if (sd == RIGHT) lane_c[sd] = clamp_col(lane_c[sd] - int'(cfg_drift));
    else lane_c[sd] = clamp_col(lane_c[sd] + int'(cfg_drift));
  endfunction

  // Advances the tracker copy by one pixel; a window close yields a point.
  function automatic void track_pixel(input bit pix, input logic [9:0] x,
                                      input bit re, input bit fs,
                                      output bit produced, output win_point_t pt,
                                      output bit ignored);
    int         lo;
    int         hi;
    int         h;
    int         top;
    int         bottom;
    int         s;
    bit         lf;
    bit         rf;
    logic [9:0] lx;
    logic [9:0] rx;
    produced = 1'b0;
    pt       = '0;
    ignored  = 1'b0;
    if (fs) begin
      lane_trk[LEFT]  = 1'b0;
      lane_trk[RIGHT] = 1'b0;
      win_row    = '0;
      win_num    = '0;
      hits[0]    = '0;
      hits[1]    = '0;
      colsum[0]  = '0;
      colsum[1]  = '0;
      frame_over = 1'b0;
    end
    if (frame_over) begin
      ignored = 1'b1;
      return;
    end
    if (pix) begin
      for (int sd = 0; sd < 2; sd++) begin
        side_bounds(sd, lo, hi);
        if (lo <= int'(x) && int'(x) < hi) begin
          hits[sd]   = hits[sd] + 18'd1;
          colsum[sd] = colsum[sd] + 28'(x);
        end
      end
    end
    if (!re) return;
    // A height of zero acts as one row per window.
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    win_row = win_row + 8'd1;
    if (int'(win_row) < h) return;
    close_side(LEFT, lf, lx);
    close_side(RIGHT, rf, rx);
    bottom = IMG_H - int'(win_num) * h;
    top    = IMG_H - (int'(win_num) + 1) * h;
    s      = top + bottom;
    pt.window_index = win_num;
    pt.center_row   = (s < 0) ? 10'd0 : 10'(s / 2);
    pt.left_found   = lf;
    pt.left_x       = lx;
    pt.right_found  = rf;
    pt.right_x      = rx;
    pt.last         = (int'(win_num) + 1 >= NUM_WIN);
    hits[0]   = '0;
    hits[1]   = '0;
    colsum[0] = '0;
    colsum[1] = '0;
    win_row   = '0;
    win_num   = win_num + 6'd1;
    if (pt.last) frame_over = 1'b1;
    produced = 1'b1;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output side: random back-pressure, none during a calm stretch.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Each output beat is checked against the oldest pending window point.
  always @(posedge clk) begin : result_check
    win_point_t got;
    win_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tlast, m_tdata[37:0]};
      if (expected_points.size() == 0) begin
        $display("%0t ns: window point expected none, got %p", $time, got);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        check_field("window_index", int'(want.window_index), int'(got.window_index));
        check_field("center_row", int'(want.center_row), int'(got.center_row));
        check_field("left_found", int'(want.left_found), int'(got.left_found));
        check_field("left_x", int'(want.left_x), int'(got.left_x));
        check_field("right_found", int'(want.right_found), int'(got.right_found));
        check_field("right_x", int'(want.right_x), int'(got.right_x));
        check_field("last_window", int'(want.last), int'(got.last));
      end
    end
  end

  // Register write; the block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= CFG_DW'(value);
    @(posedge clk);
    case (idx)
      REG_WINDOW_HEIGHT: cfg_height = value[7:0];
      REG_MIN_PIXELS:    cfg_minpix = value[7:0];
      REG_MARGIN:        cfg_margin = value[8:0];
      REG_DRIFT:         cfg_drift  = value[5:0];
      REG_SPLIT_COLUMN:  cfg_split  = value[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int h, input int mp, input int mg, input int dr,
                              input int sp);
    write_reg(REG_WINDOW_HEIGHT, h);
    write_reg(REG_MIN_PIXELS, mp);
    write_reg(REG_MARGIN, mg);
    write_reg(REG_DRIFT, dr);
    write_reg(REG_SPLIT_COLUMN, sp);
    cfg_we <= 1'b0;
  endtask

  // Holds the pixel stream until every pending window point has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_points.size() != 0);
  endtask

  // Sends one pixel, with random gaps ahead unless calm, and books its result.
  task automatic send_pixel(input bit pix, input logic [9:0] x, input bit re,
                            input bit fs, input bit typed, input win_point_t typed_pt,
                            output bit ignored);
    bit         produced;
    win_point_t pt;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, x, pix};
    s_tlast  <= re;
    s_tuser  <= fs;
    do begin
      @(posedge clk);
    end while (!s_tready);
    track_pixel(pix, x, re, fs, produced, pt, ignored);
    if (typed) expected_points.insert(expected_points.size(), typed_pt);
    else if (produced) expected_points.insert(expected_points.size(), pt);
  endtask

  // Random frames: most pixels sit near a left and a right lane, the rest
  // are spread over every column. Restarts and dropped pixels add noise.
  task automatic run_phase(input phase_t ph);
    int sent;
    int row_left;
    int left_lane;
    int right_lane;
    int spread;
    int v;
    int r;
    bit fs_next;
    bit fs;
    bit ign;
    sent       = 0;
    row_left   = 0;
    fs_next    = 1'b1;
    left_lane  = 0;
    right_lane = 0;
    spread     = 0;
    while (sent < ph.items) begin
      if (row_left == 0) row_left = $urandom_range(1, ph.max_row);
      fs = fs_next || ($urandom_range(99) < ph.restart_pct);
      fs_next = 1'b0;
      if (fs) begin
        left_lane  = $urandom_range(0, 450);
        right_lane = $urandom_range(300, 767);
        spread     = $urandom_range(0, 24);
      end
      r = $urandom_range(99);
      if (r < 40) v = left_lane + int'($urandom_range(0, 2 * spread)) - spread;
      else if (r < 80) v = right_lane + int'($urandom_range(0, 2 * spread)) - spread;
      else v = $urandom_range(0, 1023);
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      send_pixel($urandom_range(99) < 70, 10'(v), row_left == 1, fs, 1'b0, '0, ign);
      row_left--;
      if (!ign) sent++;
      if (ph.hold && sent == ph.items / 2) drain();
      // After the last window, sometimes feed a pixel that must be dropped.
      if (frame_over) begin
        if ($urandom_range(2) == 0) begin
          send_pixel(1'($urandom_range(1)), 10'($urandom_range(1023)),
                     1'($urandom_range(1)), 1'b0, 1'b0, '0, ign);
        end
        fs_next  = 1'b1;
        row_left = 0;
      end
    end
  endtask

  // Main sequence: reset, the directed table, then the random stretches.
  initial begin : stimulus
    probe_t rows[26];
    phase_t phases[8];
    bit     ign;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    reset_tracker();

    // Zero height means one row per window, so every row end closes one.
    // Pixels on the lower edge of each split range fall back to the middle.
    rows[0] = '{1'b1, 1'b1, 0, 1'b0, 1'b0, '0};
    rows[1] = '{1'b0, 1'b1, 384, 1'b1, 1'b1,
                '{1'b0, 10'd576, 1'b1, 10'd191, 1'b1, 10'd479, 6'd0}};
    rows[2] = '{1'b0, 1'b0, 1023, 1'b1, 1'b1,
                '{1'b0, 10'd0, 1'b0, 10'd0, 1'b0, 10'd478, 6'd1}};
    rows[3] = '{1'b0, 1'b1, 1023, 1'b0, 1'b0, '0};
    rows[4] = '{1'b0, 1'b1, 215, 1'b0, 1'b0, '0};
    rows[5] = '{1'b0, 1'b1, 220, 1'b1, 1'b0, '0};
    // A new frame drops tracking; the column two below the split is
    // inside the left range and the split minus one belongs to neither.
    rows[6] = '{1'b1, 1'b1, 382, 1'b1, 1'b1,
                '{1'b0, 10'd0, 1'b0, 10'd382, 1'b1, 10'd479, 6'd0}};
    rows[7] = '{1'b1, 1'b1, 383, 1'b1, 1'b1,
                '{1'b0, 10'd0, 1'b0, 10'd0, 1'b0, 10'd479, 6'd0}};
    for (int k = 0; k < 16; k++) begin
      rows[8 + k] = '{1'b0, 1'b1, (97 + 53 * k) % 1024, 1'b1, 1'b0, '0};
    end
    // Final window of the frame, then a pixel that is dropped.
    rows[24] = '{1'b0, 1'b0, 0, 1'b1, 1'b1,
                 '{1'b1, 10'd0, 1'b0, 10'd0, 1'b0, 10'd462, 6'd17}};
    rows[25] = '{1'b0, 1'b1, 100, 1'b1, 1'b0, '0};

    apply_config(0, 0, 50, 12, 384);
    foreach (rows[k]) begin
      send_pixel(rows[k].pix, 10'(rows[k].x), rows[k].re, rows[k].fs, rows[k].typed,
                 rows[k].pt, ign);
    end

    // Low extremes, then the top of each register but the height, then
    // tall windows, the upper ones below row zero, then random settings.
    phases[0] = '{1, 0, 0, 0, 1, 150, 4, 2, 1'b1, 1'b1};
    phases[1] = '{1, 255, 511, 63, 1023, 100, 6, 2, 1'b0, 1'b0};
    phases[2] = '{255, 0, 100, 5, 769, 270, 1, 0, 1'b0, 1'b0};
    phases[3] = '{32, 0, 50, 12, 384, 530, 1, 0, 1'b0, 1'b0};
    for (int p = 4; p < 8; p++) begin
      phases[p] = '{$urandom_range(1, 6), $urandom_range(0, 6), $urandom_range(0, 511),
                    $urandom_range(0, 63), $urandom_range(1, 1023), 120, 10, 2,
                    1'b0, 1'b0};
    end

    foreach (phases[p]) begin
      drain();
      repeat (SETTLE_CYCLES) @(posedge clk);
      calm = phases[p].calm;
      apply_config(phases[p].height, phases[p].minpix, phases[p].margin,
                   phases[p].drift, phases[p].split);
      run_phase(phases[p]);
    end

    calm = 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_lane_tracker_core: match");
    end else begin
      $display("sliding_window_lane_tracker_core: mismatch");
    end
    $finish;
  end

  // Run limit, far above the slowest passing run.
  initial begin
    #10_000_000;
    $display("sliding_window_lane_tracker_core: mismatch");
    $finish;
  end

endmodule

[sim.f]
hdl/swlt_pkg.sv
hdl/sliding_window_lane_tracker_core.sv
test/tb.sv
